/* hw/rtl/aemc_pkg.sv */
// Shared types and constants of the averaged moisture calibrator.
`default_nettype none

package aemc_pkg;

    // Default values of the top-level parameters.
    localparam int BURST_LENGTH_DEF = 32;
    localparam int SAMPLE_BITS_DEF  = 12;

    // Depth of the queue between the accumulating front and the back end.
    localparam int QUEUE_DEPTH = 2;

    // Configuration port geometry and register indexes.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DRY   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WET   = 2'd2;

    localparam logic [8:0]         ALPHA_RESET = 9'd64;
    localparam logic signed [12:0] LEVEL_UNSET = -13'sd1;

    // Divider geometry: the percentage quotient needs a 20-bit dividend and a
    // 13-bit divisor (twice the calibration span).
    localparam int PCT_DIV_W = 20;
    localparam int DIV_DEN_W = 13;

    // Percentage codes.
    localparam logic signed [7:0] PCT_NONE  = -8'sd1;
    localparam logic signed [7:0] PCT_EMPTY = 8'sd0;
    localparam logic signed [7:0] PCT_FULL  = 8'sd100;

    typedef struct packed {
        logic [8:0]         alpha_q8;
        logic signed [12:0] dry_level;
        logic signed [12:0] wet_level;
    } cfg_regs_t;

endpackage

`default_nettype wire

/* hw/rtl/averaged_ema_moisture_calibrator_unit.sv */
// Top level of the burst-averaging, smoothed, calibrated moisture sensor.
//
// Usage: samples enter on the in channel (sample, read_failed) with valid and
// ready; every BURST_LENGTH good samples in a row form a burst, and a failed
// read discards the burst so far without a result. Each completed burst
// gives one transfer on the out channel: raw_mean, filtered_level and
// moisture_pct (-1 when the dry and wet levels are unusable).
// Registers alpha_q8, dry_level and wet_level are written on the cfg channel,
// which is always ready; write them only while the block is idle.
// The front takes one sample per cycle while the two-entry burst queue has
// room. The back end forms the mean by reciprocal multiplication in states
// ST_MDIV and ST_MFIX and smooths and calibrates in ST_MULA, ST_MULB, ST_SUM,
// ST_FILT and ST_CAL; out_valid is registered and rises when ST_CAL ends or,
// for a percentage strictly inside 0..100, after the iterative divide ends.
// With a ready receiver the back end is through with each burst total before
// the front can complete the next, so at the defaults the input never stalls.
// Reset restores the register defaults (alpha 64, levels unset), empties the
// queue and clears the burst and the smoother. A stalled receiver holds the
// result; the back end then waits, the queue fills and in_ready falls.
`default_nettype none

module averaged_ema_moisture_calibrator_unit #(
    parameter int BURST_LENGTH = aemc_pkg::BURST_LENGTH_DEF,
    parameter int SAMPLE_BITS  = aemc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [SAMPLE_BITS-1:0]          sample,
    input  logic                            read_failed,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [SAMPLE_BITS-1:0]          raw_mean,
    output logic [SAMPLE_BITS-1:0]          filtered_level,
    output logic signed [7:0]               moisture_pct,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [aemc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [aemc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import aemc_pkg::*;

    localparam int SUM_W = SAMPLE_BITS + $clog2(BURST_LENGTH);

    cfg_regs_t cfg_reg, cfg_next;

    logic             q_push;
    logic [SUM_W-1:0] q_push_data;
    logic             q_full;
    logic             q_pop;
    logic             q_valid;
    logic [SUM_W-1:0] q_data;

    // Configuration writes complete in the cycle they are offered. An index
    // beyond the register list is accepted and ignored.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ALPHA: cfg_next.alpha_q8  = cfg_data[8:0];
                REG_DRY:   cfg_next.dry_level = cfg_data;
                REG_WET:   cfg_next.wet_level = cfg_data;
                default:   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.alpha_q8  <= ALPHA_RESET;
            cfg_reg.dry_level <= LEVEL_UNSET;
            cfg_reg.wet_level <= LEVEL_UNSET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // The front sums samples and hands each finished burst total to the queue.
    aemc_front #(
        .BURST_LENGTH (BURST_LENGTH),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .SUM_W        (SUM_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .sample      (sample),
        .read_failed (read_failed),
        .push        (q_push),
        .push_data   (q_push_data),
        .full        (q_full)
    );

    // The queue lets the front keep collecting while the back end works.
    aemc_queue #(
        .W     (SUM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .data      (q_data)
    );

    // The back end turns one burst total into one result transfer.
    aemc_back #(
        .BURST_LENGTH (BURST_LENGTH),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .SUM_W        (SUM_W)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .q_valid        (q_valid),
        .q_data         (q_data),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .raw_mean       (raw_mean),
        .filtered_level (filtered_level),
        .moisture_pct   (moisture_pct)
    );

endmodule

`default_nettype wire

/* hw/rtl/aemc_front.sv */
// Front end: accepts samples and accumulates bursts into totals.
`default_nettype none

module aemc_front #(
    parameter int BURST_LENGTH = aemc_pkg::BURST_LENGTH_DEF,
    parameter int SAMPLE_BITS  = aemc_pkg::SAMPLE_BITS_DEF,
    parameter int SUM_W        = SAMPLE_BITS + $clog2(BURST_LENGTH)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic                   read_failed,
    output logic                   push,
    output logic [SUM_W-1:0]       push_data,
    input  logic                   full
);
    import aemc_pkg::*;

    localparam int POS_W = $clog2(BURST_LENGTH + 1);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(BURST_LENGTH - 1);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [SUM_W-1:0] total_reg, total_next;
    logic [SUM_W-1:0] total_sum;
    logic             accept;

    assign in_ready  = !full;
    assign accept    = in_valid && in_ready;
    assign total_sum = total_reg + SUM_W'(sample);
    assign push_data = total_sum;

    always_comb
    begin
        pos_next   = pos_reg;
        total_next = total_reg;
        push       = 1'b0;
        if (accept)
        begin
            if (read_failed)
            begin
                // A failed read throws away the burst collected so far.
                pos_next   = '0;
                total_next = '0;
            end
            else if (pos_reg == POS_LAST)
            begin
                push       = 1'b1;
                pos_next   = '0;
                total_next = '0;
            end
            else
            begin
                pos_next   = pos_reg + POS_W'(1);
                total_next = total_sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            total_reg <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            total_reg <= total_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/aemc_queue.sv */
// Short first-in first-out queue of burst totals between front and back.
`default_nettype none

module aemc_queue #(
    parameter int W     = 17,
    parameter int DEPTH = aemc_pkg::QUEUE_DEPTH
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic         valid,
    output logic [W-1:0] data
);
    import aemc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [W-1:0]     entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_FULL);
    assign valid = (count_reg != '0);
    assign data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count exceeds its depth");
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("push into a full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> valid)
        else $error("pop from an empty queue");

endmodule

`default_nettype wire

/* hw/rtl/aemc_divider.sv */
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none

module aemc_divider #(
    parameter int DW = 20,
    parameter int VW = aemc_pkg::DIV_DEN_W
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);
    import aemc_pkg::*;

    localparam int CNT_W = $clog2(DW + 1);

    logic [VW-1:0]    rem_reg, rem_next;
    logic [DW-1:0]    quo_reg, quo_next;
    logic [VW-1:0]    dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [VW:0]      trial;
    logic [VW:0]      trial_sub;
    logic             fits;

    assign trial     = {rem_reg, quo_reg[DW-1]};
    assign trial_sub = trial - {1'b0, dvs_reg};
    assign fits      = (trial >= {1'b0, dvs_reg});
    assign done      = done_reg;
    assign quotient  = quo_reg;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(DW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // The partial remainder stays below the divisor, so VW bits hold it.
            rem_next = fits ? trial_sub[VW-1:0] : trial[VW-1:0];
            quo_next = {quo_reg[DW-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

endmodule

`default_nettype wire

/* hw/rtl/aemc_back.sv */
// Back end: burst mean, moving average, calibration and the result register.
`default_nettype none

module aemc_back #(
    parameter int BURST_LENGTH = aemc_pkg::BURST_LENGTH_DEF,
    parameter int SAMPLE_BITS  = aemc_pkg::SAMPLE_BITS_DEF,
    parameter int SUM_W        = SAMPLE_BITS + $clog2(BURST_LENGTH)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  aemc_pkg::cfg_regs_t       cfg,
    input  logic                      q_valid,
    input  logic [SUM_W-1:0]          q_data,
    output logic                      q_pop,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [SAMPLE_BITS-1:0]    raw_mean,
    output logic [SAMPLE_BITS-1:0]    filtered_level,
    output logic signed [7:0]         moisture_pct
);
    import aemc_pkg::*;

    localparam int SMW  = SAMPLE_BITS + 8;
    localparam int PRW  = SMW + 9;
    localparam int CW   = ((SAMPLE_BITS > 12) ? SAMPLE_BITS : 12) + 2;
    localparam int DDW  = PCT_DIV_W;
    localparam int HALF = BURST_LENGTH / 2;
    localparam int RCW  = SUM_W + 1;
    localparam int MPW  = SUM_W + RCW;
    localparam logic signed [CW-1:0] LVL_MAX = CW'((1 << SAMPLE_BITS) - 1);
    localparam logic [RCW-1:0] MEAN_RECIP =
        RCW'((longint'(1) << SUM_W) / longint'(BURST_LENGTH));
    localparam logic [SUM_W-1:0] BL_SUM = SUM_W'(BURST_LENGTH);

    typedef enum logic [8:0] {
        ST_IDLE = 9'b0_0000_0001,
        ST_MDIV = 9'b0_0000_0010,
        ST_MFIX = 9'b0_0000_0100,
        ST_MULA = 9'b0_0000_1000,
        ST_MULB = 9'b0_0001_0000,
        ST_SUM  = 9'b0_0010_0000,
        ST_FILT = 9'b0_0100_0000,
        ST_CAL  = 9'b0_1000_0000,
        ST_PDIV = 9'b1_0000_0000
    } back_state_t;

    back_state_t state_reg, state_next;
    logic              out_valid_reg, out_valid_next;
    logic              primed_reg, primed_next;
    logic [SMW-1:0]    sm_reg, sm_next;
    logic [SUM_W-1:0]  mx_reg, mx_next;
    logic [SAMPLE_BITS-1:0] qe_reg, qe_next;
    logic [SAMPLE_BITS-1:0] mean_reg, mean_next;
    logic [SAMPLE_BITS-1:0] filt_reg, filt_next;
    logic [PRW-1:0]    p1_reg, p1_next;
    logic [PRW-1:0]    p2_reg, p2_next;
    logic signed [7:0] pct_reg, pct_next;

    logic [8:0]        a_eff;
    logic [8:0]        a_inv;
    logic [PRW:0]      blend_sum;
    logic [SMW:0]      filt_sum;

    logic [MPW-1:0]    mean_prod;
    logic [SUM_W-1:0]  mean_back;
    logic [SUM_W-1:0]  mean_rem;

    logic signed [CW-1:0] dry_x, wet_x, f_x, diff, den, diff_a, den_a;
    logic              cal_ok;
    logic [DDW-1:0]    cal_dividend;

    logic              div_start;
    logic [DDW-1:0]    div_dividend;
    logic [DIV_DEN_W-1:0] div_divisor;
    logic              div_done;
    logic [DDW-1:0]    div_quotient;

    aemc_divider #(
        .DW (DDW),
        .VW (DIV_DEN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Weight of the newest mean, with zero taken as one and anything above
    // one whole taken as one whole.
    assign a_eff = (cfg.alpha_q8 == 9'd0) ? 9'd1 :
                   (cfg.alpha_q8 > 9'd256) ? 9'd256 : cfg.alpha_q8;
    assign a_inv = 9'd256 - a_eff;

    assign blend_sum = (PRW+1)'(p1_reg) + (PRW+1)'(p2_reg) + (PRW+1)'(128);
    assign filt_sum  = (SMW+1)'(sm_reg) + (SMW+1)'(128);

    // Rounded mean by reciprocal multiplication. The estimate is at most one
    // below the true quotient, so one compare of the remainder corrects it.
    assign mean_prod = MPW'(mx_reg) * MPW'(MEAN_RECIP);
    assign mean_back = SUM_W'(qe_reg) * BL_SUM;
    assign mean_rem  = mx_reg - mean_back;

    // Calibration arithmetic, oriented so that the span is positive.
    always_comb
    begin
        dry_x  = {{(CW-13){cfg.dry_level[12]}}, cfg.dry_level};
        wet_x  = {{(CW-13){cfg.wet_level[12]}}, cfg.wet_level};
        f_x    = CW'(filt_reg);
        diff   = f_x - dry_x;
        den    = wet_x - dry_x;
        diff_a = den[CW-1] ? -diff : diff;
        den_a  = den[CW-1] ? -den : den;
        cal_ok = !dry_x[CW-1] && (dry_x <= LVL_MAX) &&
                 !wet_x[CW-1] && (wet_x <= LVL_MAX) && (den != '0);
        cal_dividend = DDW'(diff_a[11:0]) * DDW'(200) + DDW'(den_a[11:0]);
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        primed_next    = primed_reg;
        sm_next        = sm_reg;
        mx_next        = mx_reg;
        qe_next        = qe_reg;
        mean_next      = mean_reg;
        filt_next      = filt_reg;
        p1_next        = p1_reg;
        p2_next        = p2_reg;
        pct_next       = pct_reg;
        q_pop          = 1'b0;
        div_start      = 1'b0;
        div_dividend   = '0;
        div_divisor    = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                // A new burst starts only once the previous result has left.
                if (q_valid && !out_valid_reg)
                begin
                    q_pop      = 1'b1;
                    mx_next    = q_data + SUM_W'(HALF);
                    state_next = ST_MDIV;
                end
            end
            ST_MDIV:
            begin
                qe_next    = mean_prod[SUM_W+SAMPLE_BITS-1:SUM_W];
                state_next = ST_MFIX;
            end
            ST_MFIX:
            begin
                mean_next  = (mean_rem >= BL_SUM) ? qe_reg + SAMPLE_BITS'(1) : qe_reg;
                state_next = ST_MULA;
            end
            ST_MULA:
            begin
                p1_next    = PRW'(a_eff) * PRW'({mean_reg, 8'h00});
                state_next = ST_MULB;
            end
            ST_MULB:
            begin
                p2_next    = PRW'(a_inv) * PRW'(sm_reg);
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                sm_next     = primed_reg ? blend_sum[SMW+7:8] : {mean_reg, 8'h00};
                primed_next = 1'b1;
                state_next  = ST_FILT;
            end
            ST_FILT:
            begin
                filt_next  = filt_sum[SMW-1:8];
                state_next = ST_CAL;
            end
            ST_CAL:
            begin
                if (!cal_ok)
                begin
                    pct_next       = PCT_NONE;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
                else if (diff_a[CW-1] || (diff_a == '0))
                begin
                    pct_next       = PCT_EMPTY;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
                else if (diff_a >= den_a)
                begin
                    pct_next       = PCT_FULL;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    div_start    = 1'b1;
                    div_dividend = cal_dividend;
                    div_divisor  = {den_a[11:0], 1'b0};
                    state_next   = ST_PDIV;
                end
            end
            ST_PDIV:
            begin
                if (div_done)
                begin
                    pct_next       = div_quotient[7:0];
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            primed_reg    <= 1'b0;
            sm_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            primed_reg    <= primed_next;
            sm_reg        <= sm_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mx_reg   <= mx_next;
        qe_reg   <= qe_next;
        mean_reg <= mean_next;
        filt_reg <= filt_next;
        p1_reg   <= p1_next;
        p2_reg   <= p2_next;
        pct_reg  <= pct_next;
    end

    assign out_valid      = out_valid_reg;
    assign raw_mean       = mean_reg;
    assign filtered_level = filt_reg;
    assign moisture_pct   = pct_reg;

    a_one_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready) |=> !out_valid)
        else $error("result delivered twice");
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(raw_mean) &&
            $stable(filtered_level) && $stable(moisture_pct)))
        else $error("result changed while waiting");
    a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_PDIV))
        else $error("divider finished outside the divide state");

endmodule

`default_nettype wire

/* test/tb_averaged_ema_moisture_calibrator_unit.sv */
// Testbench for the burst-averaging, smoothed, calibrated moisture sensor unit.
`timescale 1ns / 100ps

module tb_averaged_ema_moisture_calibrator_unit;

    import aemc_pkg::*;

    localparam int BURST_LEN = BURST_LENGTH_DEF;
    localparam int SAMPLE_W  = SAMPLE_BITS_DEF;
    localparam int LEVEL_MAX = (1 << SAMPLE_W) - 1;

    // Cycles to let pass after the last expected result before the block is
    // treated as idle.
    localparam int DRAIN_CYCLES = 60;
    // Length of the deliberate receiver hold-off that fills the burst queue.
    localparam int LONG_HOLD = 400;
    // Cycles in a row without any transfer after which the run is abandoned.
    localparam int WATCHDOG_LIMIT = 5000;

    // Index 3 is not a register; writes to it must leave the block unchanged.
    localparam logic [CFG_IDX_W-1:0]  REG_SPARE     = 2'd3;
    localparam logic [CFG_DATA_W-1:0] LEVEL_MOST_NEG = 13'h1000;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                read_failed;
    } sensor_item_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] raw_mean;
        logic [SAMPLE_W-1:0] filtered_level;
        logic signed [7:0]   moisture_pct;
    } moisture_result_t;

    // Clock and reset.
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #2 clk = ~clk;

    // Block inputs, all known from time zero.
    logic                  in_valid    = 1'b0;
    logic [SAMPLE_W-1:0]   sample      = '0;
    logic                  read_failed = 1'b0;
    logic                  out_ready   = 1'b0;
    logic                  cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = REG_ALPHA;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;

    // Block outputs.
    logic                  in_ready;
    logic                  out_valid;
    logic                  cfg_ready;
    logic [SAMPLE_W-1:0]   raw_mean;
    logic [SAMPLE_W-1:0]   filtered_level;
    logic signed [7:0]     moisture_pct;

    averaged_ema_moisture_calibrator_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .sample         (sample),
        .read_failed    (read_failed),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .raw_mean       (raw_mean),
        .filtered_level (filtered_level),
        .moisture_pct   (moisture_pct),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // Samples waiting to be offered, and results the predictor has worked out
    // but the block has not yet delivered.
    sensor_item_t     pending_samples[$];
    moisture_result_t expected_results[$];

    int error_count = 0;

    // Traffic shaping controls, written by the sequencer with nonblocking
    // assignments and read by the driver and the monitor.
    logic sender_steady   = 1'b0;
    logic receiver_steady = 1'b0;
    int   hold_requests   = 0;

    // ------------------------------------------------------------------
    // Predictor: its own copy of the calibration registers and the burst
    // and smoother state, updated on every accepted sample.
    // ------------------------------------------------------------------
    logic [8:0]         cal_alpha = ALPHA_RESET;
    logic signed [12:0] cal_dry   = LEVEL_UNSET;
    logic signed [12:0] cal_wet   = LEVEL_UNSET;

    int          burst_count = 0;
    logic [16:0] burst_sum   = '0;
    logic [19:0] ema_q8      = '0;
    logic        ema_seeded  = 1'b0;

    // Maps a filtered level through the dry and wet points to a percentage,
    // rounded half up with exact integer division and clamped to 0..100.
    function automatic logic signed [7:0] calibrated_percent(input int level);
        longint num;
        longint den;
        // Negative levels mean unset; equal levels give no usable span.
        if (cal_dry < 0 || cal_wet < 0 || cal_dry == cal_wet)
            return PCT_NONE;
        num = 100 * (longint'(level) - longint'(cal_dry));
        den = longint'(cal_wet) - longint'(cal_dry);
        // A dry level above the wet level is a falling scale; flip both.
        if (den < 0)
        begin
            num = -num;
            den = -den;
        end
        if (num <= 0)
            return PCT_EMPTY;
        if (num >= 100 * den)
            return PCT_FULL;
        return 8'((2 * num + den) / (2 * den));
    endfunction

    // Folds one accepted sample into the burst; a completed burst yields
    // one expected result.
    task automatic accumulate_sample(input logic [SAMPLE_W-1:0] value, input logic failed);
        moisture_result_t res;
        int unsigned      mean;
        int unsigned      weight;
        int unsigned      level;
        // A failed read throws away the burst so far but keeps the smoother.
        if (failed)
        begin
            burst_count = 0;
            burst_sum   = '0;
            return;
        end
        burst_sum   = burst_sum + value;
        burst_count = burst_count + 1;
        if (burst_count < BURST_LEN)
            return;

        mean        = (int'(burst_sum) + BURST_LEN / 2) / BURST_LEN;
        burst_count = 0;
        burst_sum   = '0;

        // Alpha of zero acts as one, anything above 256 as 256.
        weight = cal_alpha;
        if (weight == 0)
            weight = 1;
        if (weight > 256)
            weight = 256;

        // The first mean seeds the average; later ones blend in, rounded half up.
        if (!ema_seeded)
        begin
            ema_q8     = 20'(mean << 8);
            ema_seeded = 1'b1;
        end
        else
        begin
            ema_q8 = 20'((weight * (mean << 8) + (256 - weight) * ema_q8 + 128) >> 8);
        end
        level = (ema_q8 + 128) >> 8;

        res.raw_mean       = mean[SAMPLE_W-1:0];
        res.filtered_level = level[SAMPLE_W-1:0];
        res.moisture_pct   = calibrated_percent(int'(level));
        expected_results.push_back(res);
    endtask

    // Idle stretch length shared by both sides: mostly none, often short,
    // now and then long.
    function automatic int idle_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        $display("mismatch at %0t ns: %s", $time, what);
    endtask

    // ------------------------------------------------------------------
    // Driver: offers pending samples on the in channel. A new item is
    // presented only once the previous transfer has happened, so valid and
    // the payload hold steady while the block stalls. Except when the sender
    // is set steady, the gap after each transfer is drawn at random, which
    // spreads idle cycles over every position within a burst.
    // ------------------------------------------------------------------
    int           send_idle_left = 0;
    sensor_item_t next_item;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid       <= 1'b0;
            sample         <= '0;
            read_failed    <= 1'b0;
            send_idle_left = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                accumulate_sample(sample, read_failed);
            if (!in_valid || in_ready)
            begin
                if (send_idle_left > 0)
                begin
                    send_idle_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_samples.size() > 0)
                begin
                    next_item      = pending_samples.pop_front();
                    in_valid       <= 1'b1;
                    sample         <= next_item.sample;
                    read_failed    <= next_item.read_failed;
                    send_idle_left = sender_steady ? 0 : idle_length();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks every result transfer against the oldest expectation
    // and shapes out_ready. A hold request from the sequencer makes the
    // receiver refuse results until a countdown loaded from LONG_HOLD runs out.
    // ------------------------------------------------------------------
    int               recv_stall_left = 0;
    int               holds_served    = 0;
    moisture_result_t oldest_expected;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready       <= 1'b0;
            recv_stall_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result mean %0d level %0d pct %0d",
                                              raw_mean, filtered_level, moisture_pct));
                end
                else
                begin
                    oldest_expected = expected_results.pop_front();
                    if (raw_mean !== oldest_expected.raw_mean)
                        report_mismatch($sformatf("raw_mean %0d, expected %0d",
                                                  raw_mean, oldest_expected.raw_mean));
                    if (filtered_level !== oldest_expected.filtered_level)
                        report_mismatch($sformatf("filtered_level %0d, expected %0d",
                                                  filtered_level,
                                                  oldest_expected.filtered_level));
                    if (moisture_pct !== oldest_expected.moisture_pct)
                        report_mismatch($sformatf("moisture_pct %0d, expected %0d",
                                                  moisture_pct,
                                                  oldest_expected.moisture_pct));
                end
            end

            if (holds_served != hold_requests)
            begin
                holds_served++;
                recv_stall_left = LONG_HOLD;
                out_ready       <= 1'b0;
            end
            else if (recv_stall_left > 0)
            begin
                recv_stall_left--;
                out_ready <= 1'b0;
            end
            else if (receiver_steady)
            begin
                out_ready <= 1'b1;
            end
            else
            begin
                recv_stall_left = idle_length();
                out_ready       <= (recv_stall_left == 0);
            end
        end
    end

    // Watchdog: any transfer on any channel counts as progress.
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
                    $display("status: fail");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencer helpers.
    // ------------------------------------------------------------------
    task automatic queue_item(input int value, input logic failed);
        sensor_item_t item;
        item.sample      = SAMPLE_W'(value);
        item.read_failed = failed;
        pending_samples.push_back(item);
    endtask

    task automatic queue_run(input int value, input int count);
        for (int k = 0; k < count; k++)
            queue_item(value, 1'b0);
    endtask

    // Mostly complete bursts with random content; the rest are bursts cut
    // short by a failed read and stray failed reads between bursts. Every
    // sequence leaves the burst accumulator empty.
    task automatic queue_random_traffic(input int count);
        int added;
        int roll;
        int len;
        int pattern;
        int base;
        int amp;
        int v;
        added = 0;
        while (added < count)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 80)
                len = BURST_LEN;
            else if (roll < 92)
                len = $urandom_range(0, BURST_LEN - 1);
            else
                len = 0;
            pattern = $urandom_range(0, 3);
            base    = $urandom_range(0, LEVEL_MAX);
            case (pattern)
                0: amp = $urandom_range(0, 15);
                2:
                begin
                    base = $urandom_range(0, 1) ? LEVEL_MAX : 0;
                    amp  = 0;
                end
                default: amp = 255;
            endcase
            for (int k = 0; k < len; k++)
            begin
                if (pattern == 1)
                begin
                    v = $urandom_range(0, LEVEL_MAX);
                end
                else
                begin
                    v = base + int'($urandom_range(0, 2 * amp)) - amp;
                    if (v < 0)
                        v = 0;
                    if (v > LEVEL_MAX)
                        v = LEVEL_MAX;
                end
                queue_item(v, 1'b0);
            end
            added += len;
            if (len < BURST_LEN)
            begin
                queue_item($urandom_range(0, LEVEL_MAX), 1'b1);
                added++;
            end
        end
    endtask

    // Waits until every sample has been transferred and every expected
    // result has arrived, then lets the back end settle. The check runs on
    // the falling edge, where the driver's updates have all landed.
    task automatic wait_until_drained();
        do
            @(negedge clk);
        while (pending_samples.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Writes the three registers and the unused index, back to back, updating
    // the predictor's copy as each transfer completes. Called at a clock edge
    // while the block is idle.
    task automatic write_config(input logic [CFG_DATA_W-1:0] alpha_word,
                                input logic [CFG_DATA_W-1:0] dry_word,
                                input logic [CFG_DATA_W-1:0] wet_word);
        logic [CFG_IDX_W-1:0]  reg_index[4];
        logic [CFG_DATA_W-1:0] reg_value[4];
        reg_index = '{REG_ALPHA, REG_DRY, REG_WET, REG_SPARE};
        reg_value = '{alpha_word, dry_word, wet_word, CFG_DATA_W'($urandom())};
        for (int i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= reg_index[i];
            cfg_data  <= reg_value[i];
            do
                @(posedge clk);
            while (!cfg_ready);
            case (reg_index[i])
                REG_ALPHA: cal_alpha = reg_value[i][8:0];
                REG_DRY:   cal_dry   = reg_value[i];
                REG_WET:   cal_wet   = reg_value[i];
                default:   ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequencer: reset, directed runs at the reset settings and at full weight,
    // then phases of random traffic, each under its own calibration.
    // ------------------------------------------------------------------
    initial
    begin
        logic [CFG_DATA_W-1:0] alpha_word;
        logic [CFG_DATA_W-1:0] dry_word;
        logic [CFG_DATA_W-1:0] wet_word;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset settings leave both levels unset, so the percentage is none.
        // The all-zero burst seeds the smoother.
        queue_run(0, BURST_LEN);
        // Failed read early in a burst, and one in the slot that would have
        // completed it: neither gives a result.
        queue_run(LEVEL_MAX, 5);
        queue_item(LEVEL_MAX, 1'b1);
        queue_run(LEVEL_MAX, BURST_LEN - 1);
        queue_item(LEVEL_MAX, 1'b1);
        // Full-scale burst blends in at the default weight.
        queue_run(LEVEL_MAX, BURST_LEN);
        // A failed read with no burst in progress.
        queue_item(0, 1'b1);
        // Alternating extremes; then a mean that sits exactly on a half.
        for (int k = 0; k < BURST_LEN / 2; k++)
        begin
            queue_item(0, 1'b0);
            queue_item(LEVEL_MAX, 1'b0);
        end
        queue_run(1, BURST_LEN / 2);
        queue_run(0, BURST_LEN / 2);
        wait_until_drained();

        // Full weight on the newest mean over the widest span: midpoint,
        // just inside both ends, and both clamps.
        write_config(13'd256, 13'd0, 13'd4095);
        queue_run(2048, BURST_LEN);
        queue_run(1, BURST_LEN);
        queue_run(LEVEL_MAX - 1, BURST_LEN);
        queue_run(LEVEL_MAX, BURST_LEN);
        queue_run(0, BURST_LEN);
        wait_until_drained();

        for (int phase = 0; phase < 12; phase++)
        begin
            alpha_word = CFG_DATA_W'($urandom_range(1, 256));
            dry_word   = CFG_DATA_W'($urandom_range(0, LEVEL_MAX));
            wet_word   = CFG_DATA_W'($urandom_range(0, LEVEL_MAX));
            case (phase)
                // Slowest smoothing on a falling scale.
                0:
                begin
                    alpha_word = 13'd1;
                    dry_word   = 13'd4095;
                    wet_word   = 13'd0;
                end
                // Alpha of zero, with junk above the register's nine bits.
                1:
                begin
                    alpha_word = 13'h1E00;
                    dry_word   = 13'd1200;
                    wet_word   = 13'd3100;
                end
                // Alpha above the top, and equal levels.
                2:
                begin
                    alpha_word = 13'h1FFF;
                    dry_word   = 13'd2000;
                    wet_word   = 13'd2000;
                end
                3:
                begin
                    alpha_word = 13'd257;
                    dry_word   = LEVEL_UNSET;
                    wet_word   = 13'd3000;
                end
                4:
                begin
                    alpha_word = 13'd128;
                    dry_word   = 13'd3500;
                    wet_word   = LEVEL_MOST_NEG;
                end
                // A span of one level, so nearly every reading clamps.
                5:
                begin
                    alpha_word = ALPHA_RESET;
                    dry_word   = 13'd0;
                    wet_word   = 13'd1;
                end
                6:
                begin
                    alpha_word = 13'd200;
                    dry_word   = 13'd3000;
                    wet_word   = 13'd800;
                end
                11:
                begin
                    alpha_word = 13'd256;
                    dry_word   = 13'd4095;
                    wet_word   = 13'd4094;
                end
                default: ;
            endcase
            write_config(alpha_word, dry_word, wet_word);

            sender_steady   <= (phase == 6 || phase == 8);
            receiver_steady <= (phase == 8);

            if (phase == 6)
            begin
                // The receiver holds off while the sender keeps offering
                // samples back to back, so the burst queue fills and the
                // block must stall its input.
                hold_requests <= hold_requests + 1;
                queue_random_traffic(220);
            end
            else if (phase == 9)
            begin
                // The sender pauses until every expected result has come.
                queue_random_traffic(60);
                wait_until_drained();
                queue_random_traffic(60);
            end
            else
            begin
                queue_random_traffic(100);
            end
            wait_until_drained();
        end

        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
